// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solar to lunar date package
// Shared types, the lunar year table, the microcode encoding and helper
// functions for the solar to lunar date converter.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int BASE_YEAR     = 1900;
    localparam int LAST_YEAR_DEF = 2100;
    localparam int TABLE_LEN     = 201;
    localparam int CENTURY_2100  = 2100;
    localparam int EPOCH_OFFSET  = 31;
    localparam int DAY_W         = 17;
    localparam int IDX_W         = 8;
    localparam int WORD_W        = 17;
    localparam int TDATA_W       = 24;

    localparam logic [WORD_W-1:0] YEAR_WORDS [0:TABLE_LEN-1] = '{
        17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
        17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
        17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
        17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
        17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
        17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
        17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
        17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
        17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
        17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
        17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
        17'h0b540, 17'h0b6a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
        17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
        17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h055c0, 17'h0ab60,
        17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
        17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
        17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
        17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
        17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
        17'h04afb, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
        17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
        17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370, 17'h049f8, 17'h04970,
        17'h064b0, 17'h168a6, 17'h0ea50, 17'h06b20, 17'h1a6c4, 17'h0aae0, 17'h0a2e0,
        17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
        17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6,
        17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930,
        17'h07337, 17'h06aa0, 17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4,
        17'h0d160, 17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0,
        17'h0a9d4, 17'h0a4d0, 17'h0d150, 17'h0f252, 17'h0d520
    };

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_DAYS,
        ST_RANGE,
        ST_YEAR,
        ST_MONTH,
        ST_EMIT,
        ST_ZERO
    } step_t;

    typedef enum logic [2:0] {
        OP_CAPTURE,
        OP_DAYS,
        OP_OFFSET,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT,
        OP_ZERO
    } op_t;

    typedef enum logic [2:0] {
        CD_NEVER,
        CD_IN,
        CD_BAD,
        CD_YFIT,
        CD_MFIT,
        CD_OFREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp;
        logic  hold;
    } ctl_t;

    typedef struct packed {
        logic in_take;
        logic bad;
        logic year_fit;
        logic month_fit;
        logic out_free;
    } stat_t;

    function automatic logic [WORD_W-1:0] year_word(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        w = '0;
        if (int'(idx) < TABLE_LEN)
        begin
            w = YEAR_WORDS[idx];
        end
        return w;
    endfunction

    function automatic logic [8:0] year_days(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        logic [8:0]        sum;
        w   = year_word(idx);
        sum = 9'd348;
        for (int i = 4; i <= 15; i++)
        begin
            sum = sum + 9'(w[i]);
        end
        if (w[3:0] != 4'd0)
        begin
            sum = sum + 9'd29 + 9'(w[16]);
        end
        return sum;
    endfunction

    function automatic logic [DAY_W-1:0] total_days(input int last_idx);
        logic [DAY_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            if (i <= last_idx)
            begin
                sum = sum + DAY_W'(year_days(IDX_W'(i)));
            end
        end
        return sum;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd365;
            4'd15:   d = 9'd365;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/stl_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode ROM
// Holds the control program of the converter, one control word per step.
// ----------------------------------------------------------------------------
module stl_ucode_rom (
    input  stl_pkg::step_t pc,
    output stl_pkg::ctl_t  ctl
);
    import stl_pkg::*;

    always_comb
    begin
        case (pc)
            ST_WAIT:  ctl = '{op: OP_CAPTURE, cond: CD_IN,    jmp: ST_DAYS,  hold: 1'b1};
            ST_DAYS:  ctl = '{op: OP_DAYS,    cond: CD_NEVER, jmp: ST_WAIT,  hold: 1'b0};
            ST_RANGE: ctl = '{op: OP_OFFSET,  cond: CD_BAD,   jmp: ST_ZERO,  hold: 1'b0};
            ST_YEAR:  ctl = '{op: OP_YEAR,    cond: CD_YFIT,  jmp: ST_MONTH, hold: 1'b1};
            ST_MONTH: ctl = '{op: OP_MONTH,   cond: CD_MFIT,  jmp: ST_EMIT,  hold: 1'b1};
            ST_EMIT:  ctl = '{op: OP_EMIT,    cond: CD_OFREE, jmp: ST_WAIT,  hold: 1'b1};
            ST_ZERO:  ctl = '{op: OP_ZERO,    cond: CD_OFREE, jmp: ST_WAIT,  hold: 1'b1};
            default:  ctl = '{op: OP_CAPTURE, cond: CD_NEVER, jmp: ST_WAIT,  hold: 1'b0};
        endcase
    end

endmodule

// ===== design/stl_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter with conditional jumps, holds and fall-through to the next step.
// ----------------------------------------------------------------------------
module stl_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  stl_pkg::ctl_t  ctl,
    input  stl_pkg::stat_t stat,
    output stl_pkg::step_t pc
);
    import stl_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        case (ctl.cond)
            CD_IN:    taken = stat.in_take;
            CD_BAD:   taken = stat.bad;
            CD_YFIT:  taken = stat.year_fit;
            CD_MFIT:  taken = stat.month_fit;
            CD_OFREE: taken = stat.out_free;
            default:  taken = 1'b0;
        endcase

        if (taken)
        begin
            pc_next = ctl.jmp;
        end
        else if (ctl.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = step_t'(pc_reg + 3'd1);
        end
    end

    assign pc = pc_reg;

endmodule

// ===== design/stl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conversion datapath
// Day count, lunar year and month walk, and the output register.
// ----------------------------------------------------------------------------
module stl_datapath #(
    parameter int LAST_YEAR = stl_pkg::LAST_YEAR_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  stl_pkg::ctl_t  ctl,
    output stl_pkg::stat_t stat,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [11:0]    in_year,
    input  logic [3:0]     in_month,
    input  logic [4:0]     in_day,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [11:0]    out_year,
    output logic [3:0]     out_month,
    output logic [4:0]     out_day,
    output logic           out_leap
);
    import stl_pkg::*;

    localparam logic [DAY_W-1:0] TOTAL_DAYS = total_days(LAST_YEAR - BASE_YEAR);
    localparam logic [11:0]      YEAR_CAP   = 12'(LAST_YEAR + 1);

    logic                 out_valid_reg, out_valid_next;
    logic [11:0]          sy_reg, sy_next;
    logic [3:0]           sm_reg, sm_next;
    logic [4:0]           sd_reg, sd_next;
    logic [DAY_W-1:0]     total_reg, total_next;
    logic                 oor_reg, oor_next;
    logic [DAY_W-1:0]     off_reg, off_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [3:0]           m_reg, m_next;
    logic                 lp_reg, lp_next;
    logic [11:0]          oy_reg, oy_next;
    logic [3:0]           om_reg, om_next;
    logic [4:0]           od_reg, od_next;
    logic                 ol_reg, ol_next;

    logic [IDX_W-1:0]     dyear;
    logic [5:0]           leaps;
    logic                 leap_now;
    logic [DAY_W-1:0]     off_first;
    logic [8:0]           ylen;
    logic [4:0]           mlen;
    logic [4:0]           bit_sel;
    logic                 out_free;
    logic                 in_take;

    always_comb
    begin
        dyear    = sy_reg[IDX_W-1:0] - IDX_W'(BASE_YEAR);
        leaps    = 6'((9'(dyear) + 9'd3) >> 2) - 6'(dyear != '0)
                   - 6'(dyear >= IDX_W'(TABLE_LEN));
        leap_now = (sy_reg[1:0] == 2'b00) && (sy_reg != 12'(BASE_YEAR))
                   && (sy_reg != 12'(CENTURY_2100));
        off_first = total_reg - DAY_W'(EPOCH_OFFSET);
        ylen     = year_days(idx_reg);
        bit_sel  = 5'd16 - 5'(m_reg);
        mlen     = lp_reg ? (5'd29 + 5'(word_reg[16])) : (5'd29 + 5'(word_reg[bit_sel]));
        out_free = !out_valid_reg || out_ready;
        in_take  = (ctl.op == OP_CAPTURE) && in_valid;

        stat.in_take   = in_take;
        stat.bad       = oor_reg || (total_reg < DAY_W'(EPOCH_OFFSET))
                         || (off_first >= TOTAL_DAYS);
        stat.year_fit  = off_reg < DAY_W'(ylen);
        stat.month_fit = off_reg < DAY_W'(mlen);
        stat.out_free  = out_free;

        out_valid_next = out_valid_reg && !out_ready;
        sy_next        = sy_reg;
        sm_next        = sm_reg;
        sd_next        = sd_reg;
        total_next     = total_reg;
        oor_next       = oor_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        m_next         = m_reg;
        lp_next        = lp_reg;
        oy_next        = oy_reg;
        om_next        = om_reg;
        od_next        = od_reg;
        ol_next        = ol_reg;

        case (ctl.op)
            OP_CAPTURE:
            begin
                if (in_take)
                begin
                    sy_next = in_year;
                    sm_next = in_month;
                    sd_next = in_day;
                end
            end
            OP_DAYS:
            begin
                oor_next   = (sy_reg < 12'(BASE_YEAR)) || (sy_reg > YEAR_CAP);
                total_next = DAY_W'(dyear) * DAY_W'(365) + DAY_W'(leaps)
                             + DAY_W'(days_before(sm_reg))
                             + DAY_W'((sm_reg > 4'd2) && leap_now) + DAY_W'(sd_reg);
            end
            OP_OFFSET:
            begin
                off_next = off_first;
                idx_next = '0;
            end
            OP_YEAR:
            begin
                if (stat.year_fit)
                begin
                    word_next = year_word(idx_reg);
                    m_next    = 4'd1;
                    lp_next   = 1'b0;
                end
                else
                begin
                    off_next = off_reg - DAY_W'(ylen);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            OP_MONTH:
            begin
                if (!stat.month_fit)
                begin
                    off_next = off_reg - DAY_W'(mlen);
                    if (!lp_reg && (m_reg == word_reg[3:0]))
                    begin
                        lp_next = 1'b1;
                    end
                    else
                    begin
                        lp_next = 1'b0;
                        m_next  = m_reg + 4'd1;
                    end
                end
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oy_next        = 12'(BASE_YEAR) + 12'(idx_reg);
                    om_next        = m_reg;
                    od_next        = off_reg[4:0] + 5'd1;
                    ol_next        = lp_reg;
                end
            end
            OP_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oy_next        = '0;
                    om_next        = '0;
                    od_next        = '0;
                    ol_next        = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sy_reg    <= sy_next;
        sm_reg    <= sm_next;
        sd_reg    <= sd_next;
        total_reg <= total_next;
        oor_reg   <= oor_next;
        off_reg   <= off_next;
        idx_reg   <= idx_next;
        word_reg  <= word_next;
        m_reg     <= m_next;
        lp_reg    <= lp_next;
        oy_reg    <= oy_next;
        om_reg    <= om_next;
        od_reg    <= od_next;
        ol_reg    <= ol_next;
    end

    assign in_ready  = (ctl.op == OP_CAPTURE);
    assign out_valid = out_valid_reg;
    assign out_year  = oy_reg;
    assign out_month = om_reg;
    assign out_day   = od_reg;
    assign out_leap  = ol_reg;

endmodule

// ===== design/solar_to_lunar_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solar to lunar date converter
// Converts a Gregorian date to a Chinese lunar date for lunar years 1900 on.
// ----------------------------------------------------------------------------
// One transaction is converted at a time. A date in range passes the capture,
// day count and range check steps, then walks the year table, one year word per
// cycle, and then the months of its lunar year before the emit step. A date out
// of range goes from the range check to the zero step. The next transaction is
// taken while a result still waits in the output register.
// Dates before 1900-01-31 or after the last lunar year give all fields zero.
// ----------------------------------------------------------------------------
module solar_to_lunar_date #(
    parameter int LAST_YEAR = stl_pkg::LAST_YEAR_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // solar_year[11:0], solar_month[15:12], solar_day[20:16], zero[23:21]
    input  logic [stl_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // lunar_yr[11:0], lunar_month[15:12], lunar_day[20:16], zero[23:21]
    output logic [stl_pkg::TDATA_W-1:0]  m_axis_tdata,
    // leap_month_flag[0]
    output logic                         m_axis_tuser
);
    import stl_pkg::*;

    step_t       pc;
    ctl_t        ctl;
    stat_t       stat;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;

    stl_ucode_rom u_rom (
        .pc  (pc),
        .ctl (ctl)
    );

    stl_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .pc    (pc)
    );

    stl_datapath #(
        .LAST_YEAR (LAST_YEAR)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_year   (s_axis_tdata[11:0]),
        .in_month  (s_axis_tdata[15:12]),
        .in_day    (s_axis_tdata[20:16]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_year  (out_year),
        .out_month (out_month),
        .out_day   (out_day),
        .out_leap  (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, out_day, out_month, out_year};

endmodule

// ===== design/stl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solar to lunar date checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module stl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [stl_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tuser
);
    import stl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Output payload changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken while a conversion is in progress.");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[15:12] == 4'd0) == (m_axis_tdata[20:16] == 5'd0))
                          && ((m_axis_tdata[11:0] == 12'd0) == (m_axis_tdata[15:12] == 4'd0)))
        else $error("Result mixes zero and nonzero fields.");

endmodule

bind solar_to_lunar_date stl_checker u_stl_checker (.*);
